@@ hw/rtl/psca_pkg.sv @@
`timescale 1ns / 1ps
// package for the per-source connection admission core
// table size, field widths, status, operation and register codes, reset limits, cell chain types

package psca_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int ADDR_W        = 64;
    localparam int CNT_W         = 16;
    localparam int STATUS_W      = 2;
    localparam int PADDR_W       = 3;
    localparam int PDATA_W       = 32;

    localparam logic [STATUS_W-1:0] STATUS_DONE   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_GLOBAL = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_SOURCE = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd3;

    localparam logic OP_ADMIT   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic REG_GLOBAL_LIMIT = 1'b0;
    localparam logic REG_SOURCE_LIMIT = 1'b1;

    localparam logic [CNT_W-1:0] GLOBAL_LIMIT_RESET = 16'd1024;
    localparam logic [CNT_W-1:0] SOURCE_LIMIT_RESET = 16'd16;

    typedef struct packed {
        logic alloc;
        logic inc;
        logic dec;
    } cell_cmd_t;

    typedef struct packed {
        logic             free_seen;
        logic             hit;
        logic [CNT_W-1:0] count;
    } chain_t;

endpackage

@@ hw/rtl/psca_cell.sv @@
`timescale 1ns / 1ps
// one table entry of the admission core: address, count and valid bit
// depends on psca_pkg; chained to its neighbors through chain_t

module psca_cell import psca_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [ADDR_W-1:0] key_high,
    input  logic [ADDR_W-1:0] key_low,
    input  cell_cmd_t         cmd,
    input  chain_t            chain_in,
    output chain_t            chain_out
);

    logic              valid_reg;
    logic              hit_reg;
    logic [ADDR_W-1:0] addr_high_reg;
    logic [ADDR_W-1:0] addr_low_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              first_free;
    logic              take;

    assign first_free = !valid_reg && !chain_in.free_seen;
    assign take       = cmd.alloc && first_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            hit_reg   <= 1'b0;
        end else begin
            hit_reg <= valid_reg && (addr_high_reg == key_high) && (addr_low_reg == key_low);
            if (take) begin
                valid_reg <= 1'b1;
            end else if (cmd.dec && hit_reg && (count_reg <= CNT_W'(1))) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            addr_high_reg <= key_high;
            addr_low_reg  <= key_low;
            count_reg     <= CNT_W'(1);
        end else if (cmd.inc && hit_reg) begin
            count_reg <= count_reg + CNT_W'(1);
        end else if (cmd.dec && hit_reg) begin
            count_reg <= count_reg - CNT_W'(1);
        end
    end

    assign chain_out.free_seen = chain_in.free_seen | !valid_reg;
    assign chain_out.hit       = chain_in.hit | hit_reg;
    assign chain_out.count     = chain_in.count | (hit_reg ? count_reg : '0);

endmodule

@@ hw/rtl/psca_cfg.sv @@
`timescale 1ns / 1ps
// configuration registers of the admission core behind an apb-style port
// depends on psca_pkg for register codes and reset values

module psca_cfg import psca_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output logic [CNT_W-1:0]   global_limit,
    output logic [CNT_W-1:0]   source_limit
);

    logic [CNT_W-1:0] global_limit_reg;
    logic [CNT_W-1:0] source_limit_reg;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            global_limit_reg <= GLOBAL_LIMIT_RESET;
            source_limit_reg <= SOURCE_LIMIT_RESET;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_GLOBAL_LIMIT: global_limit_reg <= pwdata[CNT_W-1:0];
                REG_SOURCE_LIMIT: source_limit_reg <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_GLOBAL_LIMIT: prdata = PDATA_W'(global_limit_reg);
            REG_SOURCE_LIMIT: prdata = PDATA_W'(source_limit_reg);
            default:          prdata = '0;
        endcase
    end

    assign global_limit = global_limit_reg;
    assign source_limit = source_limit_reg;

endmodule

@@ hw/rtl/per_source_connection_admission_core.sv @@
`timescale 1ns / 1ps
// Per-source connection admission core. Each input transfer is one admit or release for a
// 128-bit source address; each gives exactly one result transfer with a status, the active
// connection count and the count held for that source. The source table is a row of 64 cells,
// each holding one address with its count; the valid bits clear at reset, so no clearing pass
// is needed. An item passes a lookup state, in which every cell compares its address with the
// request and registers the match, and an apply state, in which match, count and lowest free
// cell ripple along the row and the update is applied. A new item is taken in the apply state;
// a result not yet taken holds it until the output register frees. The user must write the
// limits at apb 0x0 (global) and 0x4 (source) only while the core is idle; unenforced.

module per_source_connection_admission_core import psca_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [127:0]       s_tdata,   // addr_high, addr_low
    input  logic [1:0]         s_tuser,   // operation, per_source
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [31:0]        m_tdata,   // active_count, src_count
    output logic [1:0]         m_tuser,   // status
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_LOOK  = 2'd1;
    localparam logic [1:0] ST_APPLY = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic                op_reg;
    logic                per_source_reg;
    logic [ADDR_W-1:0]   key_high_reg;
    logic [ADDR_W-1:0]   key_low_reg;
    logic [CNT_W-1:0]    active_reg, active_next;
    logic                m_tvalid_reg;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [CNT_W-1:0]    out_active_reg;
    logic [CNT_W-1:0]    out_src_reg, src_next;

    logic [CNT_W-1:0]    global_limit;
    logic [CNT_W-1:0]    source_limit;
    logic                finish;
    logic                s_fire;
    logic                found;
    logic [CNT_W-1:0]    have;
    cell_cmd_t           cmd;
    chain_t              chain [0:TABLE_ENTRIES];

    psca_cfg u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .global_limit (global_limit),
        .source_limit (source_limit)
    );

    assign chain[0] = '0;

    for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
        psca_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .key_high  (key_high_reg),
            .key_low   (key_low_reg),
            .cmd       (cmd),
            .chain_in  (chain[i]),
            .chain_out (chain[i+1])
        );
    end

    assign finish   = (state_reg == ST_APPLY) && (!m_tvalid_reg || m_tready);
    assign s_tready = (state_reg == ST_IDLE) || finish;
    assign s_fire   = s_tvalid && s_tready;

    assign found = per_source_reg && chain[TABLE_ENTRIES].hit;
    assign have  = found ? chain[TABLE_ENTRIES].count : '0;

    always_comb begin
        state_next = state_reg;
        if (s_fire) begin
            state_next = ST_LOOK;
        end else if (finish) begin
            state_next = ST_IDLE;
        end else if (state_reg == ST_LOOK) begin
            state_next = ST_APPLY;
        end
    end

    always_comb begin
        cmd         = '0;
        status_next = STATUS_DONE;
        active_next = active_reg;
        src_next    = have;
        if (op_reg == OP_ADMIT) begin
            if (active_reg >= global_limit) begin
                status_next = STATUS_GLOBAL;
            end else if (per_source_reg && (have >= source_limit)) begin
                status_next = STATUS_SOURCE;
            end else if (per_source_reg && !found && chain[TABLE_ENTRIES].free_seen == 1'b0) begin
                status_next = STATUS_FULL;
            end else begin
                active_next = active_reg + CNT_W'(1);
                if (per_source_reg) begin
                    src_next  = have + CNT_W'(1);
                    cmd.inc   = finish && found;
                    cmd.alloc = finish && !found;
                end
            end
        end else begin
            if (active_reg != '0) begin
                active_next = active_reg - CNT_W'(1);
            end
            if (found) begin
                cmd.dec  = finish;
                src_next = (have <= CNT_W'(1)) ? '0 : have - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            active_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (finish) begin
                active_reg   <= active_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            key_high_reg   <= s_tdata[ADDR_W-1:0];
            key_low_reg    <= s_tdata[2*ADDR_W-1:ADDR_W];
            op_reg         <= s_tuser[0];
            per_source_reg <= s_tuser[1];
        end
        if (finish) begin
            status_reg     <= status_next;
            out_active_reg <= active_next;
            out_src_reg    <= src_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_src_reg, out_active_reg};
    assign m_tuser  = status_reg;

endmodule

@@ hw/rtl/psca_chk.sv @@
`timescale 1ns / 1ps
// port-level checks for the admission core, bound to its top level
// depends on psca_pkg for status codes

module psca_chk import psca_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_lookup_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken during lookup");

    a_full_no_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == STATUS_FULL) |-> (m_tdata[31:16] == '0))
        else $error("table full reported for a known source");

endmodule

bind per_source_connection_admission_core psca_chk u_psca_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

@@ test/per_source_connection_admission_core_test.sv @@
`timescale 1ns / 1ps
// testbench for per_source_connection_admission_core: a directed table, then random phases over
// several limit settings and idle patterns, each result checked against its row or a predictor
// depends on psca_pkg and the core rtl only

module per_source_connection_admission_core_test;
    import psca_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CNT_W-1:0]    active;
        logic [CNT_W-1:0]    src;
    } outcome_t;

    typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;
    typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    typedef struct {
        row_kind_t        kind;
        logic             reg_idx;
        logic [CNT_W-1:0] value;
        logic             op;
        logic [63:0]      hi;
        logic [63:0]      lo;
        logic             counted;
        outcome_t         want;
    } row_t;

    localparam logic [63:0] ONES  = '1;
    localparam logic [63:0] ZEROS = '0;
    localparam logic [63:0] ALT_A = 64'h5555_5555_5555_5555;
    localparam logic [63:0] ALT_B = 64'haaaa_aaaa_aaaa_aaaa;
    localparam int POOL_SIZE = 128;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [127:0]       s_tdata = '0;   // addr_high, addr_low
    logic [1:0]         s_tuser = '0;   // operation, per_source
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [31:0]        m_tdata;        // active_count, src_count
    logic [1:0]         m_tuser;        // status
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    per_source_connection_admission_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // predictor state
    logic             slot_used [TABLE_ENTRIES];
    logic [63:0]      slot_hi   [TABLE_ENTRIES];
    logic [63:0]      slot_lo   [TABLE_ENTRIES];
    logic [CNT_W-1:0] slot_cnt  [TABLE_ENTRIES];
    logic [CNT_W-1:0] active_conns = '0;
    logic [CNT_W-1:0] global_lim = GLOBAL_LIMIT_RESET;
    logic [CNT_W-1:0] source_lim = SOURCE_LIMIT_RESET;

    outcome_t   awaited_outcomes [$];
    outcome_t   head;
    int         mismatches = 0;
    idle_mode_t idle_mode = IDLE_NONE;
    row_t       plan [$];
    logic [63:0] pool_hi [POOL_SIZE];
    logic [63:0] pool_lo [POOL_SIZE];

    initial begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            slot_used[i] = 1'b0;
            slot_hi[i]   = '0;
            slot_lo[i]   = '0;
            slot_cnt[i]  = '0;
        end
    end

    function automatic outcome_t predict_admission(logic op, logic [63:0] hi, logic [63:0] lo,
                                                   logic counted);
        int               hit;
        int               spare;
        logic [CNT_W-1:0] have;
        outcome_t         o;
        hit   = -1;
        spare = -1;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (counted && slot_used[i] && slot_hi[i] == hi && slot_lo[i] == lo)
                hit = i;
            if (!slot_used[i] && spare < 0)
                spare = i;
        end
        o.status = STATUS_DONE;
        o.src    = '0;
        if (op == OP_ADMIT) begin
            have  = (hit >= 0) ? slot_cnt[hit] : '0;
            o.src = have;
            if (active_conns >= global_lim) begin
                o.status = STATUS_GLOBAL;
            end else if (counted && have >= source_lim) begin
                o.status = STATUS_SOURCE;
            end else if (counted && hit < 0 && spare < 0) begin
                o.status = STATUS_FULL;
            end else begin
                if (counted) begin
                    if (hit < 0) begin
                        hit            = spare;
                        slot_used[hit] = 1'b1;
                        slot_hi[hit]   = hi;
                        slot_lo[hit]   = lo;
                    end
                    slot_cnt[hit] = have + 1'b1;
                    o.src         = slot_cnt[hit];
                end
                active_conns = active_conns + 1'b1;
            end
        end else begin
            if (active_conns > 0)
                active_conns = active_conns - 1'b1;
            if (hit >= 0) begin
                if (slot_cnt[hit] <= 1) begin
                    slot_used[hit] = 1'b0;
                end else begin
                    slot_cnt[hit] = slot_cnt[hit] - 1'b1;
                    o.src         = slot_cnt[hit];
                end
            end
        end
        o.active = active_conns;
        return o;
    endfunction

    function automatic void add_item(logic op, logic [63:0] hi, logic [63:0] lo, logic counted,
                                     logic [STATUS_W-1:0] st, logic [CNT_W-1:0] act,
                                     logic [CNT_W-1:0] src);
        row_t r;
        r.kind    = ROW_ITEM;
        r.reg_idx = REG_GLOBAL_LIMIT;
        r.value   = '0;
        r.op      = op;
        r.hi      = hi;
        r.lo      = lo;
        r.counted = counted;
        r.want    = '{status: st, active: act, src: src};
        plan.push_back(r);
    endfunction

    function automatic void add_reg(logic idx, logic [CNT_W-1:0] value);
        row_t r;
        r.kind    = ROW_REG;
        r.reg_idx = idx;
        r.value   = value;
        r.op      = OP_ADMIT;
        r.hi      = '0;
        r.lo      = '0;
        r.counted = 1'b0;
        r.want    = '0;
        plan.push_back(r);
    endfunction

    function automatic void refresh_pool(int odds);
        for (int i = 0; i < POOL_SIZE; i++) begin
            if ($urandom_range(99) < odds) begin
                pool_hi[i] = {$urandom, $urandom};
                pool_lo[i] = {$urandom, $urandom};
                // neighbors that share one half of the address
                if (i > 0 && $urandom_range(5) == 0)
                    pool_hi[i] = pool_hi[i-1];
                else if (i > 0 && $urandom_range(5) == 0)
                    pool_lo[i] = pool_lo[i-1];
            end
        end
    endfunction

    task automatic write_reg(logic idx, logic [CNT_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= PDATA_W'(value);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_GLOBAL_LIMIT)
            global_lim = value;
        else
            source_lim = value;
        @(posedge aclk);
    endtask

    task automatic send_item(logic op, logic [63:0] hi, logic [63:0] lo, logic counted,
                             logic typed, outcome_t want);
        outcome_t guess;
        int       pct;
        int       gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {lo, hi};
        s_tuser  <= {counted, op};
        do @(posedge aclk); while (!s_tready);
        guess = predict_admission(op, hi, lo, counted);
        awaited_outcomes.push_back(typed ? want : guess);
        pct = (idle_mode == IDLE_SENDER) ? 74 : (idle_mode == IDLE_BOTH) ? 38 : 0;
        gap = 0;
        while (pct > 0 && $urandom_range(99) < pct)
            gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (awaited_outcomes.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic run_phase(logic [CNT_W-1:0] glim, logic [CNT_W-1:0] slim, idle_mode_t mode,
                             int items, int pool_n, int admit_pct);
        logic        op;
        logic        counted;
        logic [63:0] hi;
        logic [63:0] lo;
        int          k;
        settle();
        write_reg(REG_GLOBAL_LIMIT, glim);
        write_reg(REG_SOURCE_LIMIT, slim);
        idle_mode = mode;
        refresh_pool(25);
        for (int n = 0; n < items; n++) begin
            if ($urandom_range(99) < 8) begin
                // stray request for an address outside the pool
                op      = 1'($urandom_range(1));
                counted = 1'($urandom_range(1));
                hi      = {$urandom, $urandom};
                lo      = {$urandom, $urandom};
            end else begin
                k       = $urandom_range(pool_n - 1);
                op      = ($urandom_range(99) < admit_pct) ? OP_ADMIT : OP_RELEASE;
                counted = ($urandom_range(99) < 85);
                hi      = pool_hi[k];
                lo      = pool_lo[k];
            end
            send_item(op, hi, lo, counted, 1'b0, '0);
        end
    endtask

    always @(posedge aclk) begin
        if (idle_mode == IDLE_RECEIVER)
            m_tready <= ($urandom_range(99) >= 74);
        else if (idle_mode == IDLE_BOTH)
            m_tready <= ($urandom_range(99) >= 38);
        else
            m_tready <= 1'b1;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (awaited_outcomes.size() == 0) begin
                $error("result transfer with no request outstanding");
                mismatches++;
            end else begin
                head = awaited_outcomes.pop_front();
                if (m_tuser !== head.status) begin
                    $error("status: expected %0d, got %0d", head.status, m_tuser);
                    mismatches++;
                end
                if (m_tdata[15:0] !== head.active) begin
                    $error("active_count: expected %0d, got %0d", head.active, m_tdata[15:0]);
                    mismatches++;
                end
                if (m_tdata[31:16] !== head.src) begin
                    $error("src_count: expected %0d, got %0d", head.src, m_tdata[31:16]);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        #10_000_000;
        $display("per_source_connection_admission_core_test: errors");
        $finish;
    end

    initial begin
        add_item(OP_RELEASE, ONES,  ONES,  1'b1, STATUS_DONE,   0, 0);
        add_item(OP_ADMIT,   ONES,  ONES,  1'b1, STATUS_DONE,   1, 1);
        add_item(OP_ADMIT,   ONES,  ONES,  1'b1, STATUS_DONE,   2, 2);
        add_item(OP_ADMIT,   ZEROS, ZEROS, 1'b1, STATUS_DONE,   3, 1);
        add_item(OP_ADMIT,   ONES,  ONES,  1'b0, STATUS_DONE,   4, 0);
        add_item(OP_RELEASE, ONES,  ONES,  1'b0, STATUS_DONE,   3, 0);
        add_item(OP_RELEASE, ONES,  ONES,  1'b1, STATUS_DONE,   2, 1);
        add_item(OP_RELEASE, ONES,  ONES,  1'b1, STATUS_DONE,   1, 0);
        add_item(OP_RELEASE, ONES,  ONES,  1'b1, STATUS_DONE,   0, 0);
        add_item(OP_RELEASE, ZEROS, ZEROS, 1'b1, STATUS_DONE,   0, 0);
        add_reg(REG_SOURCE_LIMIT, 1);
        add_item(OP_ADMIT,   ONES,  ONES,  1'b1, STATUS_DONE,   1, 1);
        add_item(OP_ADMIT,   ONES,  ONES,  1'b1, STATUS_SOURCE, 1, 1);
        add_item(OP_ADMIT,   ALT_A, ALT_B, 1'b0, STATUS_DONE,   2, 0);
        add_reg(REG_GLOBAL_LIMIT, 2);
        add_item(OP_ADMIT,   ZEROS, ZEROS, 1'b1, STATUS_GLOBAL, 2, 0);
        add_item(OP_ADMIT,   ONES,  ONES,  1'b1, STATUS_GLOBAL, 2, 1);
        add_reg(REG_SOURCE_LIMIT, 0);
        add_reg(REG_GLOBAL_LIMIT, GLOBAL_LIMIT_RESET);
        add_item(OP_ADMIT,   ZEROS, ZEROS, 1'b1, STATUS_SOURCE, 2, 0);
        add_item(OP_ADMIT,   ALT_B, ALT_A, 1'b0, STATUS_DONE,   3, 0);
        add_item(OP_RELEASE, ONES,  ONES,  1'b1, STATUS_DONE,   2, 0);
        add_item(OP_RELEASE, ALT_A, ALT_B, 1'b0, STATUS_DONE,   1, 0);
        add_item(OP_RELEASE, ALT_B, ALT_A, 1'b0, STATUS_DONE,   0, 0);
        add_reg(REG_SOURCE_LIMIT, SOURCE_LIMIT_RESET);
        add_item(OP_ADMIT,   ALT_A, ONES,  1'b1, STATUS_DONE,   1, 1);
        add_item(OP_ADMIT,   ZEROS, ONES,  1'b1, STATUS_DONE,   2, 1);
        add_item(OP_ADMIT,   ALT_A, ZEROS, 1'b1, STATUS_DONE,   3, 1);
        refresh_pool(100);

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_REG) begin
                settle();
                write_reg(plan[i].reg_idx, plan[i].value);
            end else begin
                send_item(plan[i].op, plan[i].hi, plan[i].lo, plan[i].counted, 1'b1,
                          plan[i].want);
            end
        end

        run_phase(GLOBAL_LIMIT_RESET, SOURCE_LIMIT_RESET, IDLE_NONE, 260, 24, 60);
        run_phase(16'hffff, 2, IDLE_SENDER, 260, 96, 85);
        run_phase(6, 16'hffff, IDLE_RECEIVER, 220, 10, 60);
        run_phase(0, 1, IDLE_BOTH, 140, 20, 50);
        run_phase(16'hffff, 0, IDLE_NONE, 160, 20, 60);
        run_phase(400, 16'hffff, IDLE_BOTH, 300, 80, 70);
        run_phase(16'hffff, 3, IDLE_SENDER, 180, 110, 80);

        settle();
        repeat (8) @(posedge aclk);
        if (mismatches == 0)
            $display("per_source_connection_admission_core_test: clean");
        else
            $display("per_source_connection_admission_core_test: errors");
        $finish;
    end

endmodule
